@@ hdl/slc_pkg.sv @@
// ----------------------------------------------------------------------------
// Solar load cutoff package
// Shared constants, codes and types for the solar load cutoff unit.
// ----------------------------------------------------------------------------
package slc_pkg;

    localparam int TIME_BITS = 32;

    localparam int ACTION_W = 2;
    localparam int NOW_W    = 32;
    localparam int SOC_W    = 7;
    localparam int PV_W     = 16;
    localparam int MODE_W   = 2;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CMP_W    = 64;

    typedef logic [TIME_BITS-1:0] time_t;

    localparam logic [ACTION_W-1:0] ACT_UPDATE  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_ENABLE  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_DISABLE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SOC_CUTOFF  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PV_CUTOFF   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PV_TIMEOUT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ERR_HOLDOFF = 2'd3;

    localparam logic [SOC_W-1:0] SOC_CUTOFF_RST  = 7'd20;
    localparam logic [PV_W-1:0]  PV_CUTOFF_RST   = 16'd10;
    localparam logic [CFG_W-1:0] PV_TIMEOUT_RST  = 32'd60000;
    localparam logic [CFG_W-1:0] ERR_HOLDOFF_RST = 32'd60000;

    typedef struct packed {
        logic [SOC_W-1:0] soc_cutoff;
        logic [PV_W-1:0]  pv_cutoff;
        logic [CFG_W-1:0] low_pv_timeout_ms;
        logic [CFG_W-1:0] error_holdoff_ms;
    } cfg_t;

    typedef struct packed {
        logic [MODE_W-1:0] load_state;
        logic              load_on;
        logic              state_changed;
    } result_t;

endpackage

@@ hdl/solar_load_cutoff_fsm_unit.sv @@
// ----------------------------------------------------------------------------
// Solar load cutoff unit
// Registered: a result beat is valid in the cycle after its input is accepted.
// One beat per cycle unless out_ready stalls; the output refills while drained.
// Reset clears the mode to inactive, both timers to zero and the thresholds
// to their defaults; the output register comes out of reset empty.
// ----------------------------------------------------------------------------
module solar_load_cutoff_fsm_unit
    import slc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [ACTION_W-1:0]  action,
    input  logic [NOW_W-1:0]     now_ms,
    input  logic [SOC_W-1:0]     battery_soc,
    input  logic [PV_W-1:0]      pv_power,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [MODE_W-1:0]    load_state,
    output logic                 load_on,
    output logic                 state_changed
);

    cfg_t    cfg_reg;
    logic    out_valid_reg;
    result_t result_reg;
    result_t result_next;
    logic    step;

    assign in_ready = !out_valid_reg || out_ready;
    assign step     = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.soc_cutoff        <= SOC_CUTOFF_RST;
            cfg_reg.pv_cutoff         <= PV_CUTOFF_RST;
            cfg_reg.low_pv_timeout_ms <= PV_TIMEOUT_RST;
            cfg_reg.error_holdoff_ms  <= ERR_HOLDOFF_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_SOC_CUTOFF:  cfg_reg.soc_cutoff        <= cfg_wdata[SOC_W-1:0];
                CFG_PV_CUTOFF:   cfg_reg.pv_cutoff         <= cfg_wdata[PV_W-1:0];
                CFG_PV_TIMEOUT:  cfg_reg.low_pv_timeout_ms <= cfg_wdata;
                CFG_ERR_HOLDOFF: cfg_reg.error_holdoff_ms  <= cfg_wdata;
                default:         cfg_reg                   <= cfg_reg;
            endcase
        end
    end

    slc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .action (action),
        .now    (TIME_BITS'(now_ms)),
        .soc    (battery_soc),
        .pv     (pv_power),
        .cfg    (cfg_reg),
        .result (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign load_state    = result_reg.load_state;
    assign load_on       = result_reg.load_on;
    assign state_changed = result_reg.state_changed;

endmodule

@@ hdl/slc_ctrl.sv @@
// ----------------------------------------------------------------------------
// Solar load cutoff controller
// Holds the load mode and the fault timers and resolves one beat per step.
// ----------------------------------------------------------------------------
module slc_ctrl
    import slc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [ACTION_W-1:0] action,
    input  time_t               now,
    input  logic [SOC_W-1:0]    soc,
    input  logic [PV_W-1:0]     pv,
    input  cfg_t                cfg,
    output result_t             result
);

    typedef enum logic [MODE_W-1:0] {
        MODE_INACTIVE = 2'd0,
        MODE_ACTIVE   = 2'd1,
        MODE_LOW_PV   = 2'd2,
        MODE_LOW_BATT = 2'd3
    } mode_t;

    mode_t mode_reg;
    mode_t mode_next;
    mode_t cand;
    time_t good_time_reg;
    time_t good_time_next;
    time_t fault_time_reg;
    time_t fault_time_next;
    time_t pv_elapsed;
    time_t fault_elapsed;
    logic  soc_low;
    logic  pv_low;
    logic  pv_timed_out;
    logic  in_holdoff;

    assign soc_low       = soc < cfg.soc_cutoff;
    assign pv_low        = pv < cfg.pv_cutoff;
    assign pv_elapsed    = now - good_time_reg;
    assign fault_elapsed = now - fault_time_reg;
    assign pv_timed_out  = CMP_W'(pv_elapsed) > CMP_W'(cfg.low_pv_timeout_ms);
    assign in_holdoff    = CMP_W'(fault_elapsed) <= CMP_W'(cfg.error_holdoff_ms);

    always_comb
    begin
        mode_next       = mode_reg;
        good_time_next  = good_time_reg;
        fault_time_next = fault_time_reg;
        cand            = mode_reg;
        case (action)
            ACT_ENABLE:
            begin
                if (mode_reg == MODE_INACTIVE)
                begin
                    mode_next       = MODE_ACTIVE;
                    good_time_next  = now;
                    fault_time_next = '0;
                end
            end
            ACT_DISABLE:
            begin
                mode_next = MODE_INACTIVE;
            end
            ACT_UPDATE:
            begin
                case (mode_reg)
                    MODE_ACTIVE:
                    begin
                        if (soc_low)
                        begin
                            cand = MODE_LOW_BATT;
                        end
                        else if (pv_low)
                        begin
                            if (pv_timed_out)
                            begin
                                cand = MODE_LOW_PV;
                            end
                        end
                        else
                        begin
                            good_time_next = now;
                        end
                    end
                    MODE_LOW_BATT:
                    begin
                        if (!soc_low)
                        begin
                            cand = MODE_ACTIVE;
                        end
                    end
                    MODE_LOW_PV:
                    begin
                        if (!pv_low)
                        begin
                            cand = MODE_ACTIVE;
                        end
                    end
                    default:
                    begin
                        cand = mode_reg;
                    end
                endcase
                if (cand == MODE_LOW_BATT || cand == MODE_LOW_PV)
                begin
                    if (cand != mode_reg)
                    begin
                        fault_time_next = now;
                    end
                    mode_next = cand;
                end
                else if (cand == MODE_ACTIVE && mode_reg != MODE_ACTIVE)
                begin
                    if (!in_holdoff)
                    begin
                        mode_next = MODE_ACTIVE;
                    end
                end
            end
            default:
            begin
                mode_next = mode_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_INACTIVE;
            good_time_reg  <= '0;
            fault_time_reg <= '0;
        end
        else if (step)
        begin
            mode_reg       <= mode_next;
            good_time_reg  <= good_time_next;
            fault_time_reg <= fault_time_next;
        end
    end

    assign result.load_state    = mode_next;
    assign result.load_on       = (mode_next == MODE_ACTIVE);
    assign result.state_changed = (mode_next != mode_reg);

endmodule
